// ===== src/im2col_pkg.sv =====
package im2col_pkg;

   // Default store geometry
   localparam int MAX_CHANNELS_DEF = 8;
   localparam int MAX_ROWS_DEF     = 32;
   localparam int MAX_COLS_DEF     = 32;
   localparam int MAX_KERNEL_DEF   = 8;
   localparam int DATA_BITS_DEF    = 32;

   // Configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 6;

   localparam logic [CSR_INDEX_BITS-1:0] REG_STRIDE_ROWS = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STRIDE_COLS = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PAD_TOP     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PAD_LEFT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KERNEL_ROWS = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KERNEL_COLS = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_ROWS  = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_COLS  = 3'd7;

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [2:0]  chan;
      logic [4:0]  img_row;
      logic [4:0]  img_col;
      logic [31:0] load_value;
      logic [5:0]  win_row;
      logic [5:0]  win_col;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] elem_value;
      logic        is_padding;
      logic [2:0]  kernel_row_idx;
      logic [2:0]  kernel_col_idx;
      logic        last;
   } rsp_payload_type;

endpackage

// ===== src/im2col_req_if.sv =====
interface im2col_req_if;
   logic                         valid;
   logic                         ready;
   im2col_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/im2col_rsp_if.sv =====
interface im2col_rsp_if;
   logic                         valid;
   logic                         ready;
   im2col_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/im2col_ram.sv =====
module im2col_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/im2col_patch_extract.sv =====
// Load beat: written into the image store at the accepting edge if it is in range.
// Fetch beat: kernel_rows*kernel_cols result beats (each clamped to 1..MAX_KERNEL),
// one per cycle from the single read port of the image store while the output is not
// stalled. The next request is taken once the last element read of a fetch is issued.
// Reset (synchronous, active high) restores register defaults and clears control;
// the image store is not cleared and reads as undefined until loaded.
module im2col_patch_extract #(
   parameter int MAX_CHANNELS = im2col_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_ROWS     = im2col_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS     = im2col_pkg::MAX_COLS_DEF,
   parameter int MAX_KERNEL   = im2col_pkg::MAX_KERNEL_DEF,
   parameter int DATA_BITS    = im2col_pkg::DATA_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   im2col_req_if.sink                             req_ch,
   im2col_rsp_if.source                           rsp_ch,
   input  logic                                   csr_we,
   input  logic [im2col_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [im2col_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int STORE_DEPTH = MAX_CHANNELS * MAX_ROWS * MAX_COLS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int PLANE       = MAX_ROWS * MAX_COLS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // configuration registers
   logic [3:0] stride_rows_ff, stride_cols_ff, kernel_rows_ff, kernel_cols_ff;
   logic [2:0] pad_top_ff, pad_left_ff;
   logic [5:0] image_rows_ff, image_cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_rows_ff <= 4'd1;
         stride_cols_ff <= 4'd1;
         pad_top_ff     <= 3'd0;
         pad_left_ff    <= 3'd0;
         kernel_rows_ff <= 4'd3;
         kernel_cols_ff <= 4'd3;
         image_rows_ff  <= 6'd32;
         image_cols_ff  <= 6'd32;
      end else if (csr_we) begin
         case (csr_index)
            im2col_pkg::REG_STRIDE_ROWS: stride_rows_ff <= csr_wdata[3:0];
            im2col_pkg::REG_STRIDE_COLS: stride_cols_ff <= csr_wdata[3:0];
            im2col_pkg::REG_PAD_TOP:     pad_top_ff     <= csr_wdata[2:0];
            im2col_pkg::REG_PAD_LEFT:    pad_left_ff    <= csr_wdata[2:0];
            im2col_pkg::REG_KERNEL_ROWS: kernel_rows_ff <= csr_wdata[3:0];
            im2col_pkg::REG_KERNEL_COLS: kernel_cols_ff <= csr_wdata[3:0];
            im2col_pkg::REG_IMAGE_ROWS:  image_rows_ff  <= csr_wdata;
            im2col_pkg::REG_IMAGE_COLS:  image_cols_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // request side
   logic state_ff, state_in;
   logic req_accept, load_accept, fetch_accept;
   logic load_ok;
   logic [ADDR_W-1:0] wr_addr;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign load_accept  = req_accept && (req_ch.payload.req_type == im2col_pkg::REQ_LOAD);
   assign fetch_accept = req_accept && (req_ch.payload.req_type == im2col_pkg::REQ_FETCH);

   assign load_ok = (int'(req_ch.payload.chan) < MAX_CHANNELS) &&
                    (int'(req_ch.payload.img_row) < MAX_ROWS) &&
                    (int'(req_ch.payload.img_col) < MAX_COLS);
   assign wr_addr = ADDR_W'(req_ch.payload.chan) * ADDR_W'(PLANE) +
                    ADDR_W'(req_ch.payload.img_row) * ADDR_W'(MAX_COLS) +
                    ADDR_W'(req_ch.payload.img_col);

   // fetch context, latched at accept
   logic [2:0]  kr_ff, kr_in, kc_ff, kc_in;
   logic [3:0]  kr_n_ff, kr_n_in, kc_n_ff, kc_n_in;
   logic [5:0]  h_ff, h_in, w_ff, w_in;
   logic [9:0]  row_base_ff, row_base_in, col_base_ff, col_base_in;
   logic [2:0]  chan_ff, chan_in;
   logic        chan_ok_ff, chan_ok_in;

   always_comb begin
      if (kernel_rows_ff == 4'd0) begin
         kr_n_in = 4'd1;
      end else if (int'(kernel_rows_ff) > MAX_KERNEL) begin
         kr_n_in = 4'(MAX_KERNEL);
      end else begin
         kr_n_in = kernel_rows_ff;
      end
      if (kernel_cols_ff == 4'd0) begin
         kc_n_in = 4'd1;
      end else if (int'(kernel_cols_ff) > MAX_KERNEL) begin
         kc_n_in = 4'(MAX_KERNEL);
      end else begin
         kc_n_in = kernel_cols_ff;
      end
      h_in = (int'(image_rows_ff) > MAX_ROWS) ? 6'(MAX_ROWS) : image_rows_ff;
      w_in = (int'(image_cols_ff) > MAX_COLS) ? 6'(MAX_COLS) : image_cols_ff;
      row_base_in = 10'(req_ch.payload.win_row) * 10'(stride_rows_ff);
      col_base_in = 10'(req_ch.payload.win_col) * 10'(stride_cols_ff);
      chan_in     = req_ch.payload.chan;
      chan_ok_in  = int'(req_ch.payload.chan) < MAX_CHANNELS;
   end

   always_ff @(posedge clock) begin
      if (fetch_accept) begin
         kr_n_ff     <= kr_n_in;
         kc_n_ff     <= kc_n_in;
         h_ff        <= h_in;
         w_ff        <= w_in;
         row_base_ff <= row_base_in;
         col_base_ff <= col_base_in;
         chan_ff     <= chan_in;
         chan_ok_ff  <= chan_ok_in;
      end
   end

   // element address and bounds
   logic [10:0] pos_r, pos_c, idx_r, idx_c;
   logic        row_in, col_in, elem_inside, elem_last;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      pos_r  = 11'(row_base_ff) + 11'(kr_ff);
      pos_c  = 11'(col_base_ff) + 11'(kc_ff);
      idx_r  = pos_r - 11'(pad_top_ff);
      idx_c  = pos_c - 11'(pad_left_ff);
      row_in = (pos_r >= 11'(pad_top_ff)) && (idx_r < 11'(h_ff));
      col_in = (pos_c >= 11'(pad_left_ff)) && (idx_c < 11'(w_ff));
      elem_inside = chan_ok_ff && row_in && col_in;
      elem_last   = ((4'(kr_ff) + 4'd1) == kr_n_ff) && ((4'(kc_ff) + 4'd1) == kc_n_ff);
      rd_addr = ADDR_W'(chan_ff) * ADDR_W'(PLANE) +
                ADDR_W'(idx_r) * ADDR_W'(MAX_COLS) + ADDR_W'(idx_c);
   end

   // read pipeline: issue -> s1 (ram data) -> output register
   logic issue, s1_adv;
   logic s1_valid_ff, s1_valid_in;
   logic s1_pad_ff, s1_last_ff;
   logic [2:0] s1_kr_ff, s1_kc_ff;
   logic rsp_valid_ff, rsp_valid_in;
   im2col_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic [DATA_BITS-1:0] rd_data;

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign issue  = (state_ff == ST_RUN) && (!s1_valid_ff || s1_adv);

   always_comb begin
      state_in = state_ff;
      kr_in    = kr_ff;
      kc_in    = kc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (fetch_accept) begin
               state_in = ST_RUN;
               kr_in    = 3'd0;
               kc_in    = 3'd0;
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (elem_last) begin
                  state_in = ST_IDLE;
               end else if ((4'(kc_ff) + 4'd1) == kc_n_ff) begin
                  kc_in = 3'd0;
                  kr_in = kr_ff + 3'd1;
               end else begin
                  kc_in = kc_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign s1_valid_in  = issue || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ch.ready);

   always_comb begin
      rsp_data_in.elem_value     = s1_pad_ff ? 32'd0 : 32'(rd_data);
      rsp_data_in.is_padding     = s1_pad_ff;
      rsp_data_in.kernel_row_idx = s1_kr_ff;
      rsp_data_in.kernel_col_idx = s1_kc_ff;
      rsp_data_in.last           = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kr_ff        <= 3'd0;
         kc_ff        <= 3'd0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kr_ff        <= kr_in;
         kc_ff        <= kc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_pad_ff  <= !elem_inside;
         s1_kr_ff   <= kr_ff;
         s1_kc_ff   <= kc_ff;
         s1_last_ff <= elem_last;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   im2col_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_accept && load_ok),
      .wr_addr (wr_addr),
      .wr_data (DATA_BITS'(req_ch.payload.load_value)),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_kr_ff) &&
                                    $stable(s1_kc_ff) && $stable(s1_last_ff)))
      else $error("s1 stage changed while stalled");

   a_fetch_start: assert property (@(posedge clock) disable iff (reset)
      fetch_accept |=> (state_ff == ST_RUN && kr_ff == 3'd0 && kc_ff == 3'd0))
      else $error("fetch did not start at filter origin");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (issue && elem_last) |=> (state_ff == ST_IDLE))
      else $error("sequencer ran past last element");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.is_padding) |-> (rsp_data_ff.elem_value == 32'd0))
      else $error("padding beat carries nonzero data");

endmodule
